// ----- hdl/neural_activation_unit_macros.svh -----
// Assertion macros for the activation unit.
// Used by nau_front and nau_select; no other dependencies.
`ifndef NEURAL_ACTIVATION_UNIT_MACROS_SVH
`define NEURAL_ACTIVATION_UNIT_MACROS_SVH

// same-cycle implication, off while in reset
`define NAU_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off while in reset
`define NAU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/nau_pkg.sv -----
// Package for the activation unit: widths, command codes, pipeline structs
// and the sigmoid lookup table. No dependencies.
package nau_pkg;

    localparam int X_W           = 16;
    localparam int Y_W           = 16;
    localparam int CMD_W         = 3;
    localparam int LEAK_W        = 13;
    localparam int FRAC_BITS     = 12;
    localparam int TABLE_ENTRIES = 64;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);
    localparam int RR_W          = X_W - IDX_W;
    localparam int LUT_W         = FRAC_BITS;
    localparam int SIG_W         = FRAC_BITS + 1;
    localparam int DIFF_W        = 8;
    localparam int PROD_W        = DIFF_W + RR_W;
    localparam int NEG_W         = X_W;
    localparam int LPROD_W       = NEG_W + LEAK_W;
    localparam int LKM_W         = LPROD_W + 1 - FRAC_BITS;
    localparam int SQ_W          = 2 * SIG_W;
    localparam int RND_W         = SQ_W + 1 - FRAC_BITS;
    localparam int ACC_W         = 20;

    localparam logic [SIG_W-1:0]  ONE_SIG    = SIG_W'(1 << FRAC_BITS);
    localparam logic [SIG_W-1:0]  HALF_SIG   = SIG_W'(1 << (FRAC_BITS - 1));
    localparam logic [LEAK_W-1:0] LEAK_RESET = LEAK_W'(41);
    localparam logic signed [X_W-1:0] X_MIN  = {1'b1, {(X_W-1){1'b0}}};
    localparam logic signed [X_W-1:0] X_MAX  = {1'b0, {(X_W-1){1'b1}}};

    typedef enum logic [CMD_W-1:0] {
        CMD_SIG    = 3'd0,
        CMD_DSIG   = 3'd1,
        CMD_DTANH  = 3'd2,
        CMD_RELU   = 3'd3,
        CMD_DRELU  = 3'd4,
        CMD_LEAKY  = 3'd5,
        CMD_DLEAKY = 3'd6
    } t_cmd;

    typedef struct packed {
        logic [CMD_W-1:0]     cmd;
        logic signed [X_W-1:0] x;
    } t_side;

    typedef struct packed {
        t_side              side;
        logic [SIG_W-1:0]   sig;
        logic [SIG_W-1:0]   op_a;
        logic [SIG_W-1:0]   op_b;
        logic [LKM_W-1:0]   leak_mag;
    } t_front;

    typedef struct packed {
        t_side              side;
        logic [SIG_W-1:0]   sig;
        logic [LKM_W-1:0]   leak_mag;
        logic [SQ_W-1:0]    sq;
    } t_back;

    // round(4096 * sigmoid(-8 + k/4)), k = 0..64
    function automatic logic [LUT_W-1:0] sig_lut(input logic [IDX_W:0] k);
        logic [LUT_W-1:0] v;
        case (k)
            7'd0:  v = 12'd1;    7'd1:  v = 12'd2;    7'd2:  v = 12'd2;
            7'd3:  v = 12'd3;    7'd4:  v = 12'd4;    7'd5:  v = 12'd5;
            7'd6:  v = 12'd6;    7'd7:  v = 12'd8;    7'd8:  v = 12'd10;
            7'd9:  v = 12'd13;   7'd10: v = 12'd17;   7'd11: v = 12'd21;
            7'd12: v = 12'd27;   7'd13: v = 12'd35;   7'd14: v = 12'd45;
            7'd15: v = 12'd58;   7'd16: v = 12'd74;   7'd17: v = 12'd94;
            7'd18: v = 12'd120;  7'd19: v = 12'd153;  7'd20: v = 12'd194;
            7'd21: v = 12'd246;  7'd22: v = 12'd311;  7'd23: v = 12'd391;
            7'd24: v = 12'd488;  7'd25: v = 12'd606;  7'd26: v = 12'd747;
            7'd27: v = 12'd912;  7'd28: v = 12'd1102; 7'd29: v = 12'd1314;
            7'd30: v = 12'd1546; 7'd31: v = 12'd1793; 7'd32: v = 12'd2048;
            7'd33: v = 12'd2303; 7'd34: v = 12'd2550; 7'd35: v = 12'd2782;
            7'd36: v = 12'd2994; 7'd37: v = 12'd3184; 7'd38: v = 12'd3349;
            7'd39: v = 12'd3490; 7'd40: v = 12'd3608; 7'd41: v = 12'd3705;
            7'd42: v = 12'd3785; 7'd43: v = 12'd3850; 7'd44: v = 12'd3902;
            7'd45: v = 12'd3943; 7'd46: v = 12'd3976; 7'd47: v = 12'd4002;
            7'd48: v = 12'd4022; 7'd49: v = 12'd4038; 7'd50: v = 12'd4051;
            7'd51: v = 12'd4061; 7'd52: v = 12'd4069; 7'd53: v = 12'd4075;
            7'd54: v = 12'd4079; 7'd55: v = 12'd4083; 7'd56: v = 12'd4086;
            7'd57: v = 12'd4088; 7'd58: v = 12'd4090; 7'd59: v = 12'd4091;
            7'd60: v = 12'd4092; 7'd61: v = 12'd4093; 7'd62: v = 12'd4094;
            7'd63: v = 12'd4094; 7'd64: v = 12'd4095;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ----- hdl/nau_in_if.sv -----
// Input stream interface: valid/ready with command and argument word.
// Depends on nau_pkg.
interface nau_in_if
    import nau_pkg::*;
;
    logic                  valid;
    logic                  ready;
    logic [CMD_W-1:0]      cmd;
    logic signed [X_W-1:0] x_value;

    modport source (output valid, output cmd, output x_value, input ready);
    modport sink   (input valid, input cmd, input x_value, output ready);
endinterface

// ----- hdl/nau_out_if.sv -----
// Output stream interface: valid/ready with the result word.
// Depends on nau_pkg.
interface nau_out_if
    import nau_pkg::*;
;
    logic                  valid;
    logic                  ready;
    logic signed [Y_W-1:0] y_value;

    modport source (output valid, output y_value, input ready);
    modport sink   (input valid, input y_value, output ready);
endinterface

// ----- hdl/neural_activation_unit.sv -----
// Channel   Dir  Word
// i_in      in   cmd[2:0], x_value[15:0] signed Q4.12
// o_out     out  y_value[15:0] signed Q4.12
// i_cfg_*   in   leak_slope[12:0] Q1.12, reset 41
//
// Five register stages from input to output; one word per cycle sustained
// while o_out is ready. The stage split is set by the table read, the
// interpolation multiply and the squaring multiply. Reset is synchronous,
// active low, and clears the valid bits and sets leak_slope to 41. A stall
// on o_out backs up stage by stage; empty stages still take new words.
// Depends on nau_pkg, nau_in_if, nau_out_if, nau_front, nau_square, nau_select.
module neural_activation_unit
    import nau_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_wr_en,
    input  logic [LEAK_W-1:0] i_cfg_wr_data,
    nau_in_if.sink            i_in,
    nau_out_if.source         o_out
);

    logic [LEAK_W-1:0] r_leak_slope;
    t_side             in_side;
    t_front            front;
    t_back             back;
    logic              front_v, front_rdy, back_v, back_rdy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_leak_slope <= LEAK_RESET;
        end else if (i_cfg_wr_en) begin
            r_leak_slope <= i_cfg_wr_data;
        end
    end

    assign in_side.cmd = i_in.cmd;
    assign in_side.x   = i_in.x_value;

    nau_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_leak_slope (r_leak_slope),
        .i_valid      (i_in.valid),
        .o_ready      (i_in.ready),
        .i_side       (in_side),
        .o_valid      (front_v),
        .i_ready      (front_rdy),
        .o_front      (front)
    );

    nau_square u_square (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (front_v),
        .o_ready (front_rdy),
        .i_front (front),
        .o_valid (back_v),
        .i_ready (back_rdy),
        .o_back  (back)
    );

    nau_select u_select (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_leak_slope (r_leak_slope),
        .i_valid      (back_v),
        .o_ready      (back_rdy),
        .i_back       (back),
        .o_valid      (o_out.valid),
        .i_ready      (o_out.ready),
        .o_y          (o_out.y_value)
    );

endmodule

// ----- hdl/nau_front.sv -----
// Front pipeline: argument prep and table read, interpolation and leak
// products, sigmoid sum and multiplier operands. Depends on nau_pkg and neural_activation_unit_macros.svh.
`include "neural_activation_unit_macros.svh"

module nau_front
    import nau_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [LEAK_W-1:0] i_leak_slope,
    input  logic              i_valid,
    output logic              o_ready,
    input  t_side             i_side,
    output logic              o_valid,
    input  logic              i_ready,
    output t_front            o_front
);

    // stage A
    logic                  r_a_v;
    t_side                 r_a_side;
    logic [LUT_W-1:0]      r_a_lo;
    logic [DIFF_W-1:0]     r_a_d;
    logic [RR_W-1:0]       r_a_rr;
    logic                  r_a_zero;
    logic [NEG_W-1:0]      r_a_neg;
    // stage B
    logic                  r_b_v;
    t_side                 r_b_side;
    logic [LUT_W-1:0]      r_b_lo;
    logic                  r_b_zero;
    logic [PROD_W-1:0]     r_b_prod;
    logic [LPROD_W-1:0]    r_b_lprod;
    // stage C
    logic                  r_c_v;
    t_front                r_c;

    logic en_a, en_b, en_c;
    logic signed [X_W-1:0] n_arg;
    logic [X_W-1:0]        n_off;
    logic [IDX_W-1:0]      n_idx;
    logic [LUT_W-1:0]      n_lo, n_hi;
    logic [PROD_W:0]       n_rnd;
    logic [SIG_W-1:0]      n_sig;
    logic [SIG_W-1:0]      n_mag;
    logic [LPROD_W:0]      n_lrnd;
    t_front                n_c;

    assign en_c    = !r_c_v || i_ready;
    assign en_b    = !r_b_v || en_c;
    assign en_a    = !r_a_v || en_b;
    assign o_ready = en_a;
    assign o_valid = r_c_v;
    assign o_front = r_c;

    // sigmoid argument: 2x saturated for the tanh derivative
    always_comb begin
        if (i_side.cmd == CMD_DTANH) begin
            if (i_side.x[X_W-1] != i_side.x[X_W-2]) begin
                n_arg = i_side.x[X_W-1] ? X_MIN : X_MAX;
            end else begin
                n_arg = {i_side.x[X_W-2:0], 1'b0};
            end
        end else begin
            n_arg = i_side.x;
        end
        n_off = n_arg ^ X_MIN;  // offset binary: arg + 8.0
        n_idx = n_off[X_W-1:RR_W];
        n_lo  = sig_lut({1'b0, n_idx});
        n_hi  = sig_lut({1'b0, n_idx} + (IDX_W+1)'(1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
        end else if (en_a) begin
            r_a_v <= i_valid;
        end
        if (en_a) begin
            r_a_side <= i_side;
            r_a_lo   <= n_lo;
            r_a_d    <= DIFF_W'(n_hi - n_lo);
            r_a_rr   <= n_off[RR_W-1:0];
            r_a_zero <= (n_off == '0);
            r_a_neg  <= NEG_W'(~i_side.x + 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_v <= 1'b0;
        end else if (en_b) begin
            r_b_v <= r_a_v;
        end
        if (en_b) begin
            r_b_side  <= r_a_side;
            r_b_lo    <= r_a_lo;
            r_b_zero  <= r_a_zero;
            r_b_prod  <= PROD_W'(r_a_d * r_a_rr);
            r_b_lprod <= LPROD_W'(r_a_neg * i_leak_slope);
        end
    end

    always_comb begin
        n_rnd  = {1'b0, r_b_prod} + (PROD_W+1)'(1 << (RR_W - 1));
        n_sig  = r_b_zero ? '0
                          : SIG_W'(r_b_lo) + SIG_W'(n_rnd[PROD_W:RR_W]);
        n_mag  = (n_sig >= HALF_SIG) ? SIG_W'({n_sig, 1'b0} - {1'b0, ONE_SIG})
                                     : SIG_W'({1'b0, ONE_SIG} - {n_sig, 1'b0});
        n_lrnd = {1'b0, r_b_lprod} + (LPROD_W+1)'(1 << (FRAC_BITS - 1));
        n_c.side     = r_b_side;
        n_c.sig      = n_sig;
        n_c.leak_mag = n_lrnd[LPROD_W:FRAC_BITS];
        if (r_b_side.cmd == CMD_DTANH) begin
            n_c.op_a = n_mag;
            n_c.op_b = n_mag;
        end else begin
            n_c.op_a = n_sig;
            n_c.op_b = ONE_SIG - n_sig;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_v <= 1'b0;
        end else if (en_c) begin
            r_c_v <= r_b_v;
        end
        if (en_c) begin
            r_c <= n_c;
        end
    end

    `NAU_ASSERT_NOW(a_sig_range, i_clk, i_rst_n, r_c_v, r_c.sig < ONE_SIG, "sigmoid above 1")
    `NAU_ASSERT_NEXT(a_c_hold, i_clk, i_rst_n, r_c_v && !i_ready, r_c_v && $stable(r_c), "stage C lost word")

endmodule

// ----- hdl/nau_square.sv -----
// Multiplier stage: s*(1-s) or |t|*|t| product, registered.
// Depends on nau_pkg.
module nau_square
    import nau_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_valid,
    output logic   o_ready,
    input  t_front i_front,
    output logic   o_valid,
    input  logic   i_ready,
    output t_back  o_back
);

    logic  r_v;
    t_back r_back;
    logic  en;

    assign en      = !r_v || i_ready;
    assign o_ready = en;
    assign o_valid = r_v;
    assign o_back  = r_back;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (en) begin
            r_v <= i_valid;
        end
        if (en) begin
            r_back.side     <= i_front.side;
            r_back.sig      <= i_front.sig;
            r_back.leak_mag <= i_front.leak_mag;
            r_back.sq       <= SQ_W'(i_front.op_a * i_front.op_b);
        end
    end

endmodule

// ----- hdl/nau_select.sv -----
// Result stage: picks the function value, saturates, output register.
// Depends on nau_pkg and neural_activation_unit_macros.svh.
`include "neural_activation_unit_macros.svh"

module nau_select
    import nau_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [LEAK_W-1:0]     i_leak_slope,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  t_back                 i_back,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic signed [Y_W-1:0] o_y
);

    logic                    r_v;
    logic signed [Y_W-1:0]   r_y;
    logic                    en, load, pos;
    logic [SQ_W:0]           n_sum;
    logic [RND_W-1:0]        n_rnd;
    logic signed [ACC_W-1:0] n_acc;
    logic signed [Y_W-1:0]   n_y;

    assign en      = !r_v || i_ready;
    assign load    = en && i_valid;
    assign o_ready = en;
    assign o_valid = r_v;
    assign o_y     = r_y;

    always_comb begin
        pos   = !i_back.side.x[X_W-1] && (i_back.side.x != '0);
        n_sum = {1'b0, i_back.sq} + (SQ_W+1)'(1 << (FRAC_BITS - 1));
        n_rnd = n_sum[SQ_W:FRAC_BITS];
        case (t_cmd'(i_back.side.cmd))
            CMD_SIG:    n_acc = ACC_W'(i_back.sig);
            CMD_DSIG:   n_acc = ACC_W'(n_rnd);
            CMD_DTANH:  n_acc = ACC_W'(ONE_SIG) - ACC_W'(n_rnd);
            CMD_RELU:   n_acc = pos ? ACC_W'(i_back.side.x) : '0;
            CMD_DRELU:  n_acc = pos ? ACC_W'(ONE_SIG) : '0;
            CMD_LEAKY:  n_acc = pos ? ACC_W'(i_back.side.x) : -ACC_W'(i_back.leak_mag);
            CMD_DLEAKY: n_acc = pos ? ACC_W'(ONE_SIG) : ACC_W'(i_leak_slope);
            default:    n_acc = '0;
        endcase
        if (n_acc > ACC_W'(X_MAX)) begin
            n_y = X_MAX;
        end else if (n_acc < ACC_W'(X_MIN)) begin
            n_y = X_MIN;
        end else begin
            n_y = Y_W'(n_acc);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (en) begin
            r_v <= i_valid;
        end
        if (load) begin
            r_y <= n_y;
        end
    end

    `NAU_ASSERT_NEXT(a_drelu, i_clk, i_rst_n, load && i_back.side.cmd == CMD_DRELU, r_y == '0 || r_y == Y_W'(ONE_SIG), "drelu not 0 or 1")
    `NAU_ASSERT_NEXT(a_dtanh, i_clk, i_rst_n, load && i_back.side.cmd == CMD_DTANH, !r_y[Y_W-1], "dtanh negative")
    `NAU_ASSERT_NEXT(a_dsig, i_clk, i_rst_n, load && i_back.side.cmd == CMD_DSIG, r_y <= Y_W'(1 << (FRAC_BITS - 2)), "dsigmoid above 0.25")

endmodule
